### src/rie_pkg.sv
`default_nettype none

package rie_pkg;

   // major opcodes
   localparam logic [6:0] OP_ALUI = 7'h13;
   localparam logic [6:0] OP_LOAD = 7'h03;
   localparam logic [6:0] OP_JALR = 7'h67;
   localparam logic [6:0] OP_SYS  = 7'h73;

   // alu-immediate minor codes
   localparam logic [2:0] F3_ADDI  = 3'd0;
   localparam logic [2:0] F3_SLLI  = 3'd1;
   localparam logic [2:0] F3_SLTI  = 3'd2;
   localparam logic [2:0] F3_SLTIU = 3'd3;
   localparam logic [2:0] F3_XORI  = 3'd4;
   localparam logic [2:0] F3_SRI   = 3'd5;
   localparam logic [2:0] F3_ORI   = 3'd6;
   localparam logic [2:0] F3_ANDI  = 3'd7;

   // load minor codes
   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   // jalr and system use only this minor code
   localparam logic [2:0] F3_ZERO = 3'd0;

   // shift selectors in funct7
   localparam logic [6:0] F7_LOGICAL   = 7'h00;
   localparam logic [6:0] F7_ARITHMETIC = 7'h20;

   // ecall services
   localparam logic [31:0] SVC_PRINT_INT    = 32'd1;
   localparam logic [31:0] SVC_PRINT_FLOAT  = 32'd2;
   localparam logic [31:0] SVC_PRINT_STRING = 32'd4;
   localparam logic [31:0] SVC_EXIT         = 32'd10;
   localparam logic [31:0] SVC_PRINT_CHAR   = 32'd11;
   localparam logic [31:0] SVC_PRINT_HEX    = 32'd34;
   localparam logic [31:0] SVC_PRINT_BIN    = 32'd35;
   localparam logic [31:0] SVC_PRINT_UNS    = 32'd36;
   localparam logic [31:0] SVC_EXIT_CODE    = 32'd93;

   // one instruction as it enters the stage
   typedef struct packed {
      logic [6:0]  opcode;
      logic [2:0]  funct3;
      logic [6:0]  funct7;
      logic [4:0]  imm_low;
      logic [4:0]  dest_index;
      logic [31:0] src_value;
      logic [31:0] pc_value;
      logic [31:0] load_word;
      logic [31:0] service_code;
      logic [31:0] service_arg;
   } req_type;

   // one executed result
   typedef struct packed {
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        pc_write;
      logic [31:0] next_pc;
      logic [31:0] eff_address;
      logic        halt_request;
      logic        exit_code_write;
      logic [31:0] exit_code;
      logic        status;
   } rsp_type;

endpackage

`default_nettype wire

### src/rv32i_itype_execute.sv
`default_nettype none

// RV32I I-type execute stage: alu-immediate ops with shifts, loads with sign or
// zero extension, jalr and ecall exit. A transaction is accepted on start while
// busy is low; busy is high only during reset and the cycle after it. One result
// per transaction appears once it has passed the input and result registers, on
// rsp_valid for exactly one cycle; the receiver cannot stall it. While busy is low
// the stage takes one transaction every cycle: an input register feeds one pass of
// decode, adder and shifter logic into the result register, so throughput is set by
// that single pass. Illegal encodings return all fields zero with rsp_status set.
module rv32i_itype_execute
   import rie_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [6:0]  req_opcode,
   input  wire logic [2:0]  req_funct3,
   input  wire logic [6:0]  req_funct7,
   input  wire logic [4:0]  req_imm_low,
   input  wire logic [4:0]  req_dest_index,
   input  wire logic [31:0] req_src_value,
   input  wire logic [31:0] req_pc_value,
   input  wire logic [31:0] req_load_word,
   input  wire logic [31:0] req_service_code,
   input  wire logic [31:0] req_service_arg,
   output logic             rsp_valid,
   output logic             rsp_reg_write,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic             rsp_pc_write,
   output logic [31:0]      rsp_next_pc,
   output logic [31:0]      rsp_eff_address,
   output logic             rsp_halt_request,
   output logic             rsp_exit_code_write,
   output logic [31:0]      rsp_exit_code,
   output logic             rsp_status
);

   logic    busy_ff;
   logic    req_valid_ff, req_valid_in;
   req_type req_ff, req_in;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic [31:0] imm;
   logic [31:0] sum;
   logic        wr, pcw, halt, exw, bad;
   logic [31:0] val, npc, ea, exc;

   assign accept = start && !busy_ff;

   // hold busy through reset, clearing it once reset is released
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // capture the transaction
   always_comb begin
      req_valid_in        = accept;
      req_in              = req_ff;
      if (accept) begin
         req_in.opcode       = req_opcode;
         req_in.funct3       = req_funct3;
         req_in.funct7       = req_funct7;
         req_in.imm_low      = req_imm_low;
         req_in.dest_index   = req_dest_index;
         req_in.src_value    = req_src_value;
         req_in.pc_value     = req_pc_value;
         req_in.load_word    = req_load_word;
         req_in.service_code = req_service_code;
         req_in.service_arg  = req_service_arg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_ff <= req_in;
   end

   // decode and execute
   always_comb begin
      imm  = {{20{req_ff.funct7[6]}}, req_ff.funct7, req_ff.imm_low};
      sum  = req_ff.src_value + imm;
      wr   = 1'b0;
      pcw  = 1'b0;
      halt = 1'b0;
      exw  = 1'b0;
      bad  = 1'b0;
      val  = '0;
      npc  = '0;
      ea   = '0;
      exc  = '0;

      case (req_ff.opcode)
         OP_ALUI: begin
            wr = 1'b1;
            case (req_ff.funct3)
               F3_ADDI:  val = sum;
               F3_SLLI: begin
                  if (req_ff.funct7 == F7_LOGICAL) begin
                     val = req_ff.src_value << req_ff.imm_low;
                  end else begin
                     bad = 1'b1;
                  end
               end
               F3_SLTI:  val = {31'd0, $signed(req_ff.src_value) < $signed(imm)};
               F3_SLTIU: val = {31'd0, req_ff.src_value < imm};
               F3_XORI:  val = req_ff.src_value ^ imm;
               F3_SRI: begin
                  if (req_ff.funct7 == F7_LOGICAL) begin
                     val = req_ff.src_value >> req_ff.imm_low;
                  end else if (req_ff.funct7 == F7_ARITHMETIC) begin
                     val = $unsigned($signed(req_ff.src_value) >>> req_ff.imm_low);
                  end else begin
                     bad = 1'b1;
                  end
               end
               F3_ORI:   val = req_ff.src_value | imm;
               default:  val = req_ff.src_value & imm;
            endcase
         end
         OP_LOAD: begin
            wr = 1'b1;
            ea = sum;
            case (req_ff.funct3)
               F3_LB:   val = {{24{req_ff.load_word[7]}}, req_ff.load_word[7:0]};
               F3_LH:   val = {{16{req_ff.load_word[15]}}, req_ff.load_word[15:0]};
               F3_LW:   val = req_ff.load_word;
               F3_LBU:  val = {24'd0, req_ff.load_word[7:0]};
               F3_LHU:  val = {16'd0, req_ff.load_word[15:0]};
               default: bad = 1'b1;
            endcase
         end
         OP_JALR: begin
            if (req_ff.funct3 != F3_ZERO) begin
               bad = 1'b1;
            end else begin
               wr  = 1'b1;
               val = req_ff.pc_value;
               pcw = 1'b1;
               npc = {sum[31:1], 1'b0};
            end
         end
         OP_SYS: begin
            if (req_ff.funct3 != F3_ZERO || imm != 32'd0) begin
               bad = 1'b1;
            end else begin
               case (req_ff.service_code)
                  SVC_PRINT_INT, SVC_PRINT_FLOAT, SVC_PRINT_STRING, SVC_PRINT_CHAR,
                  SVC_PRINT_HEX, SVC_PRINT_BIN, SVC_PRINT_UNS: ;
                  SVC_EXIT: halt = 1'b1;
                  SVC_EXIT_CODE: begin
                     halt = 1'b1;
                     exw  = 1'b1;
                     exc  = req_ff.service_arg;
                  end
                  default: bad = 1'b1;
               endcase
            end
         end
         default: bad = 1'b1;
      endcase

      // drop writes to x0
      if (req_ff.dest_index == 5'd0) begin
         wr = 1'b0;
      end

      rsp_in.reg_write       = wr;
      rsp_in.reg_index       = wr ? req_ff.dest_index : 5'd0;
      rsp_in.reg_value       = wr ? val : 32'd0;
      rsp_in.pc_write        = pcw;
      rsp_in.next_pc         = npc;
      rsp_in.eff_address     = ea;
      rsp_in.halt_request    = halt;
      rsp_in.exit_code_write = exw;
      rsp_in.exit_code       = exc;
      rsp_in.status          = 1'b0;

      // zero everything on an illegal encoding
      if (bad) begin
         rsp_in        = '0;
         rsp_in.status = 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reg_write       = rsp_ff.reg_write;
   assign rsp_reg_index       = rsp_ff.reg_index;
   assign rsp_reg_value       = rsp_ff.reg_value;
   assign rsp_pc_write        = rsp_ff.pc_write;
   assign rsp_next_pc         = rsp_ff.next_pc;
   assign rsp_eff_address     = rsp_ff.eff_address;
   assign rsp_halt_request    = rsp_ff.halt_request;
   assign rsp_exit_code_write = rsp_ff.exit_code_write;
   assign rsp_exit_code       = rsp_ff.exit_code;
   assign rsp_status          = rsp_ff.status;

   // every accepted transaction produces a result after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   // no result without an accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_ff))
      else $error("result without a transaction");

   // illegal result carries no side effects
   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_reg_write && !rsp_pc_write &&
         !rsp_halt_request && !rsp_exit_code_write)
      else $error("illegal result has side effects");

   // exit code only together with a halt
   a_exit_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exit_code_write |-> rsp_halt_request)
      else $error("exit code without halt");

   // never write x0
   a_write_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> rsp_reg_index != 5'd0)
      else $error("write to x0");

endmodule

`default_nettype wire
